// ===== rtl/lirs_pkg.sv =====
// shared types and constants for the linear interpolation resampler
`timescale 1ns / 1ps

package lirs_pkg;

   // block limits
   localparam int MAX_OUTPUTS = 4096;
   localparam int RESULT_CAP  = 64;
   localparam int QDEPTH      = 4;

   // derived widths
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam int NCNT_W = $clog2(RESULT_CAP + 1);

   localparam logic [12:0]       TOTAL_CAP  = 13'(MAX_OUTPUTS);
   localparam logic [20:0]       MIN_STEP   = 21'd2048;
   localparam logic [12:0]       INDEX_MAX  = 13'd8191;
   localparam logic [NCNT_W-1:0] N_CAP      = NCNT_W'(RESULT_CAP);
   localparam logic [NCNT_W-1:0] N_CAP_LAST = NCNT_W'(RESULT_CAP - 1);

   // configuration register indexes
   localparam logic CSR_PHASE_STEP   = 1'b0;
   localparam logic CSR_OUTPUT_TOTAL = 1'b1;

   // one queued input transaction
   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } item_type;

   // configuration register contents
   typedef struct packed {
      logic [20:0] phase_step;
      logic [12:0] output_total;
   } cfg_type;

   // queue status seen by the top level
   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
   } q_status_type;

endpackage

// ===== rtl/linear_interp_resampler_top.sv =====
// top level of the linear interpolation resampler: registers, queue and sequencer
// first result path: an accepted transaction goes through the queue, the sequencer's
//   ST_IDLE and ST_INTERP states and the result register, when its sample pair is complete
// throughput: an input occupies the back-end sequencer through ST_IDLE and ST_INTERP,
//   and ST_FLUSH when it ends the block; one result per cycle while rsp_stall is low, queue 4 deep
// reset: synchronous; empties the queue, clears block state, phase_step to 65536,
//   output_total to 1
`timescale 1ns / 1ps

module linear_interp_resampler_top
   import lirs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_in_sample,
   input  logic               req_in_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_sample,
   output logic               rsp_out_last,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [20:0]        csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         q_valid;
   item_type     q_item;
   logic         q_pop;
   q_status_type q_status;

   // configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP:   cfg_in.phase_step   = csr_wdata;
            CSR_OUTPUT_TOTAL: cfg_in.output_total = csr_wdata[12:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{phase_step: 21'd65536, output_total: 13'd1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input queue
   lirs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_sample (req_in_sample),
      .req_in_last   (req_in_last),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .q_status      (q_status)
   );

   // interpolation sequencer
   lirs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_out_last   (rsp_out_last)
   );

   // checks
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (q_status.count != '0))
      else $error("accepted transaction missing from queue");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (q_status.full && !q_pop) |=> req_stall)
      else $error("full queue not stalling input");

endmodule

// ===== rtl/lirs_front.sv =====
// front end: accepts input transactions into a short queue
`timescale 1ns / 1ps

module lirs_front
   import lirs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_in_sample,
   input  logic               req_in_last,
   output logic               q_valid,
   output item_type           q_item,
   input  logic               q_pop,
   output q_status_type       q_status
);

   item_type          mem [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              full;
   logic              push;
   logic              pop;

   // handshake and pointer update
   always_comb begin
      full      = (count_ff == QCNT_W'(QDEPTH));
      push      = req_valid && !full;
      pop       = q_pop && (count_ff != '0);
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= '{sample: req_in_sample, last: req_in_last};
      end
   end

   // queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign req_stall = full;
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem[rd_ptr_ff];
   assign q_status  = '{count: count_ff, full: full};

endmodule

// ===== rtl/lirs_back.sv =====
// back end: phase accumulator sequencer that interpolates and flushes
`timescale 1ns / 1ps

module lirs_back
   import lirs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_sample,
   output logic               rsp_out_last
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_INTERP = 3'b010,
      ST_FLUSH  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   item_type           cur_ff, cur_in;
   logic signed [15:0] prev_ff, prev_in;
   logic [12:0]        idx_ff, idx_in;
   logic [31:0]        phase_ff, phase_in;
   logic [12:0]        done_ff, done_in;
   logic [NCNT_W-1:0]  n_ff, n_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [12:0]        total;
   logic [20:0]        step;
   logic [12:0]        pair;
   logic [12:0]        done_inc;
   logic               out_free;
   logic               owed;
   logic               interp_go;
   logic signed [16:0] diff;
   logic signed [32:0] prod;
   logic signed [17:0] interp_sum;
   logic [32:0]        phase_sum;
   logic [31:0]        phase_next;

   // effective limits and datapath
   always_comb begin
      total      = (cfg.output_total > TOTAL_CAP) ? TOTAL_CAP : cfg.output_total;
      step       = (cfg.phase_step < MIN_STEP) ? MIN_STEP : cfg.phase_step;
      pair       = 13'(idx_ff - 1'b1);
      done_inc   = 13'(done_ff + 1'b1);
      out_free   = !rsp_valid_ff || !rsp_stall;
      owed       = (done_ff < total) && (n_ff < N_CAP);
      interp_go  = owed && (idx_ff != '0) && (phase_ff[31:16] <= {3'b000, pair});
      diff       = {cur_ff.sample[15], cur_ff.sample} - {prev_ff[15], prev_ff};
      prod       = diff * $signed({1'b0, phase_ff[15:1]});
      interp_sum = {{2{prev_ff[15]}}, prev_ff} + prod[32:15];
      phase_sum  = {1'b0, phase_ff} + {12'b0, step};
      phase_next = phase_sum[32] ? '1 : phase_sum[31:0];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      done_in       = done_ff;
      n_in          = n_ff;
      q_pop         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               n_in     = '0;
               state_in = ST_INTERP;
            end
         end
         ST_INTERP: begin
            if (interp_go) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = interp_sum[15:0];
                  rsp_last_in   = (done_inc == total);
                  done_in       = done_inc;
                  n_in          = NCNT_W'(n_ff + 1'b1);
                  phase_in      = phase_next;
               end
            end else begin
               prev_in  = cur_ff.sample;
               idx_in   = (idx_ff == INDEX_MAX) ? idx_ff : 13'(idx_ff + 1'b1);
               state_in = cur_ff.last ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (owed) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = cur_ff.sample;
                  rsp_last_in   = (done_inc == total) || (n_ff == N_CAP_LAST);
                  done_in       = done_inc;
                  n_in          = NCNT_W'(n_ff + 1'b1);
               end
            end else begin
               // block ends: back to the reset state
               prev_in  = '0;
               idx_in   = '0;
               phase_in = '0;
               done_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         idx_ff       <= '0;
         phase_ff     <= '0;
         done_ff      <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         done_ff      <= done_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_out_last   = rsp_last_ff;

endmodule
